### design/v3n_pkg.sv
// Shared constants and types for the three-component vector normaliser.
package v3n_pkg;

   // Default component width and output fraction bits
   localparam int IN_WIDTH_DEF      = 16;
   localparam int OUT_FRAC_BITS_DEF = 14;

   // Side information that travels beside the arithmetic lanes
   typedef struct packed {
      logic       valid;
      logic       null_vec;
      logic [2:0] neg;
   } ctl_type;

endpackage

### design/v3n_lane.sv
// One component lane: pipelined restoring divide then pipelined integer square root.
module v3n_lane #(
   parameter int IN_WIDTH      = v3n_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = v3n_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [2*IN_WIDTH-2:0]   a2,
   input  logic [2*IN_WIDTH-1:0]   s,
   output logic [OUT_FRAC_BITS:0]  q
);

   localparam int SW  = 2 * IN_WIDTH;
   localparam int QW  = 2 * OUT_FRAC_BITS + 3;
   localparam int RW  = OUT_FRAC_BITS + 2;
   localparam int RMW = OUT_FRAC_BITS + 3;

   logic [SW-1:0]   drem_ff [QW];
   logic [QW-1:0]   dquo_ff [QW];
   logic [SW-1:0]   ds_ff   [QW];
   logic [RMW-1:0]  srem_ff [RW];
   logic [RW-1:0]   sroot_ff[RW];
   logic [2*RW-1:0] sm_ff   [RW];
   logic [RW:0]     qsum;
   logic [OUT_FRAC_BITS:0] q_ff;

   // Long division of a2 * 4^(F+1) by s, one quotient bit a stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [SW-1:0] rem_p;
      logic [SW-1:0] s_p;
      logic [QW-1:0] quo_p;
      logic          bit_in;
      logic [SW:0]   cand;
      logic          ge;
      if (k == 0) begin : g_first
         assign rem_p  = SW'(a2 >> 1);
         assign s_p    = s;
         assign quo_p  = '0;
         assign bit_in = a2[0];
      end else begin : g_next
         assign rem_p  = drem_ff[k-1];
         assign s_p    = ds_ff[k-1];
         assign quo_p  = dquo_ff[k-1];
         assign bit_in = 1'b0;
      end
      assign cand = {rem_p, bit_in};
      assign ge   = cand >= {1'b0, s_p};
      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k] <= ge ? SW'(cand - {1'b0, s_p}) : SW'(cand);
            dquo_ff[k] <= {quo_p[QW-2:0], ge};
            ds_ff[k]   <= s_p;
         end
      end
   end

   // Digit-by-digit square root of the quotient, one root bit a stage
   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      logic [2*RW-1:0] m_p;
      logic [RMW-1:0]  rem_p;
      logic [RW-1:0]   root_p;
      logic [RMW+1:0]  cand;
      logic [RMW+1:0]  trial;
      logic            ge;
      if (j == 0) begin : g_first
         assign m_p    = {1'b0, dquo_ff[QW-1]};
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign m_p    = sm_ff[j-1];
         assign rem_p  = srem_ff[j-1];
         assign root_p = sroot_ff[j-1];
      end
      assign cand  = {rem_p, m_p[2*RW-1-2*j -: 2]};
      assign trial = {1'b0, root_p, 2'b01};
      assign ge    = cand >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            srem_ff[j]  <= ge ? RMW'(cand - trial) : RMW'(cand);
            sroot_ff[j] <= {root_p[RW-2:0], ge};
            sm_ff[j]    <= m_p;
         end
      end
   end

   // Round half up: q = (root + 1) / 2
   assign qsum = (RW+1)'(sroot_ff[RW-1]) + (RW+1)'(1);

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= qsum[OUT_FRAC_BITS+1:1];
      end
   end

   assign q = q_ff;

endmodule

### design/vector3_normalize.sv
// Top level of the pipelined three-component vector normaliser.
//
// Input channel req_*: one transfer carries a vector (comp_x, comp_y, comp_z),
// signed IN_WIDTH bits each. Result channel rsp_*: one transfer per vector with
// the unit components in Q1.OUT_FRAC_BITS (rounded to nearest, ties away from
// zero) and is_null on rsp_tuser; a null vector gives zero components.
// The pipeline is 3*OUT_FRAC_BITS + 10 register stages deep (52 at the defaults).
// Stages: three front stages (magnitude, square, sum), one per quotient bit of
// the divider (2F+3), one per root bit of the square root (F+2), a rounding
// stage and the output register.
// Throughput is one vector per clock unless the receiver stalls; each divider
// or root stage is one compare and subtract, so the pipeline never iterates.
// When the receiver stalls with a result held, the whole pipeline freezes and
// a one-entry skid register takes one more input transfer before req_tready
// falls, so req_tready depends only on the skid register and reset.
// Reset (synchronous, active high) clears all valid bits and the skid, holds
// req_tready low, and the block accepts data on the cycle after release.
module vector3_normalize #(
   parameter int IN_WIDTH      = v3n_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = v3n_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // comp_x, comp_y, comp_z from bit 0 up, zero padded to bytes
   input  logic [((3*IN_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // unit_x, unit_y, unit_z from bit 0 up, zero padded to bytes
   output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // is_null
   output logic                                   rsp_tuser
);

   localparam int W   = IN_WIDTH;
   localparam int OW  = OUT_FRAC_BITS + 2;
   localparam int RTW = ((3*OW+7)/8)*8;
   localparam int LAT = 3 * OUT_FRAC_BITS + 6;
   localparam logic signed [OW-1:0] UNIT_MAX = OW'(1) << OUT_FRAC_BITS;

   logic                 en;
   logic                 req_fire;
   logic                 skid_valid_ff;
   logic [3*W-1:0]       skid_data_ff;
   logic [3*W-1:0]       src_data;
   logic                 src_valid;
   logic [W-1:0]         comp [3];
   logic [W-1:0]         mag_in [3];
   v3n_pkg::ctl_type     ctl_a_in;
   v3n_pkg::ctl_type     ctl_a_ff, ctl_b_ff, ctl_c_ff;
   v3n_pkg::ctl_type     ctl_line_ff [LAT];
   logic [W-1:0]         mag_a_ff [3];
   logic [2*W-1:0]       sq_b_ff [3];
   logic [2*W-2:0]       sq_c_ff [3];
   logic [2*W-1:0]       sum_c_ff;
   logic [OUT_FRAC_BITS:0] q_lane [3];
   logic [OW-1:0]        unit_in [3];
   logic [OW-1:0]        unit_ff [3];
   logic                 rsp_tvalid_ff;
   logic                 null_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = !skid_valid_ff && !reset;
   assign req_fire   = req_tvalid && req_tready;

   // Hold one transfer in the skid while the pipeline is frozen
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_fire) begin
         skid_data_ff <= req_tdata[3*W-1:0];
      end
   end

   assign src_valid = skid_valid_ff || req_fire;
   assign src_data  = skid_valid_ff ? skid_data_ff : req_tdata[3*W-1:0];

   // Take magnitudes, signs and the null flag
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp[i]   = src_data[i*W +: W];
         mag_in[i] = comp[i][W-1] ? (~comp[i] + W'(1)) : comp[i];
      end
      ctl_a_in.valid    = src_valid;
      ctl_a_in.null_vec = (src_data == '0);
      ctl_a_in.neg      = {comp[2][W-1], comp[1][W-1], comp[0][W-1]};
   end

   // Front stages: magnitude, square, sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
         ctl_b_ff.valid <= 1'b0;
         ctl_c_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_a_ff <= ctl_a_in;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_a_ff[i] <= mag_in[i];
            sq_b_ff[i]  <= mag_a_ff[i] * mag_a_ff[i];
            sq_c_ff[i]  <= sq_b_ff[i][2*W-2:0];
         end
         sum_c_ff <= sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      end
   end

   // Divide and root lanes
   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3n_lane #(
         .IN_WIDTH      (IN_WIDTH),
         .OUT_FRAC_BITS (OUT_FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .a2    (sq_c_ff[i]),
         .s     (sum_c_ff),
         .q     (q_lane[i])
      );
   end

   // Carry side information alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            ctl_line_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         ctl_line_ff[0] <= ctl_c_ff;
         for (int k = 1; k < LAT; k++) begin
            ctl_line_ff[k] <= ctl_line_ff[k-1];
         end
      end
   end

   // Apply signs and the null override
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (ctl_line_ff[LAT-1].null_vec) begin
            unit_in[i] = '0;
         end else if (ctl_line_ff[LAT-1].neg[i]) begin
            unit_in[i] = OW'(0) - OW'(q_lane[i]);
         end else begin
            unit_in[i] = OW'(q_lane[i]);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= ctl_line_ff[LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            unit_ff[i] <= unit_in[i];
         end
         null_ff <= ctl_line_ff[LAT-1].null_vec;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RTW'({unit_ff[2], unit_ff[1], unit_ff[0]});
   assign rsp_tuser  = null_ff;

   // A null result carries zero components
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && null_ff |->
         unit_ff[0] == '0 && unit_ff[1] == '0 && unit_ff[2] == '0)
      else $error("null vector with nonzero components");

   // Unit components never exceed one in magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |->
         $signed(unit_ff[0]) <= UNIT_MAX && $signed(unit_ff[0]) >= -UNIT_MAX &&
         $signed(unit_ff[1]) <= UNIT_MAX && $signed(unit_ff[1]) >= -UNIT_MAX &&
         $signed(unit_ff[2]) <= UNIT_MAX && $signed(unit_ff[2]) >= -UNIT_MAX)
      else $error("unit component out of range");

   // The skid fills only from a transfer taken while the pipeline is frozen
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(!en && req_fire))
      else $error("skid filled without a stall");

   // A frozen pipeline keeps its output
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> rsp_tvalid_ff && $stable(null_ff) && $stable(unit_ff[0]))
      else $error("output changed while frozen");

endmodule
